FILE: rtl/mlag_pkg.sv
// ----------------------------------------------------------------------------
// mlag_pkg
// Shared types and constants of the masked life automaton grid.
// ----------------------------------------------------------------------------
package mlag_pkg;

    localparam int unsigned CODE_W        = 8;
    localparam int unsigned PASS_W        = 8;
    localparam int unsigned RULE_W        = 2;
    localparam int unsigned OP_W          = 2;
    localparam int unsigned ROW_FIELD_W   = 6;
    localparam int unsigned COL_FIELD_W   = 6;
    localparam int unsigned STEP_W        = 4;
    localparam int unsigned COUNT_W       = 4;
    localparam int unsigned REG_IDX_W     = 3;
    localparam int unsigned APB_ADDR_W    = 5;
    localparam int unsigned APB_DATA_W    = 32;
    localparam int unsigned S_TDATA_W     = 24;
    localparam int unsigned M_TDATA_W     = 16;

    // Neighborhood sequence of one interior cell: read center, then eight
    // neighbors; read data arrives in the cycle after its read address.
    localparam logic [STEP_W-1:0] STEP_CENTER      = 4'd0;
    localparam logic [STEP_W-1:0] STEP_CENTER_DATA = 4'd1;
    localparam logic [STEP_W-1:0] STEP_FIRST_NB    = 4'd2;
    localparam logic [STEP_W-1:0] STEP_LAST_NB     = 4'd8;
    localparam logic [STEP_W-1:0] STEP_FINAL       = 4'd9;

    localparam logic [COUNT_W-1:0] SURVIVE_MIN = 4'd2;
    localparam logic [COUNT_W-1:0] SURVIVE_MAX = 4'd3;
    localparam logic [COUNT_W-1:0] BIRTH_COUNT = 4'd3;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_RUN   = 2'd2
    } op_t;

    typedef enum logic [RULE_W-1:0] {
        RULE_LIFE  = 2'd0,
        RULE_CLEAN = 2'd1,
        RULE_FILL  = 2'd2
    } rule_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_RULE_MODE   = 3'd0,
        REG_PASS_COUNT  = 3'd1,
        REG_EMPTY_CODE  = 3'd2,
        REG_LIVE_CODE   = 3'd3,
        REG_FROZEN_CODE = 3'd4
    } reg_idx_t;

    typedef enum logic {
        SEQ_IDLE  = 1'b0,
        SEQ_SWEEP = 1'b1
    } seq_state_t;

    typedef enum logic [1:0] {
        OFF_ZERO  = 2'd0,
        OFF_MINUS = 2'd1,
        OFF_PLUS  = 2'd2
    } off_t;

    typedef struct packed {
        off_t row_off;
        off_t col_off;
    } nb_off_t;

    typedef struct packed {
        logic [RULE_W-1:0] rule_mode;
        logic [CODE_W-1:0] empty_code;
        logic [CODE_W-1:0] live_code;
        logic [CODE_W-1:0] frozen_code;
    } cfg_t;

    typedef struct packed {
        logic load_center;
        logic add_live;
        logic copy;
    } step_ctl_t;

    function automatic nb_off_t nb_offset(input logic [STEP_W-1:0] step);
        nb_off_t off;
        off.row_off = OFF_ZERO;
        off.col_off = OFF_ZERO;
        case (step)
            4'd1: begin off.row_off = OFF_MINUS; off.col_off = OFF_MINUS; end
            4'd2: begin off.row_off = OFF_MINUS; off.col_off = OFF_ZERO;  end
            4'd3: begin off.row_off = OFF_MINUS; off.col_off = OFF_PLUS;  end
            4'd4: begin off.row_off = OFF_ZERO;  off.col_off = OFF_MINUS; end
            4'd5: begin off.row_off = OFF_ZERO;  off.col_off = OFF_PLUS;  end
            4'd6: begin off.row_off = OFF_PLUS;  off.col_off = OFF_MINUS; end
            4'd7: begin off.row_off = OFF_PLUS;  off.col_off = OFF_ZERO;  end
            4'd8: begin off.row_off = OFF_PLUS;  off.col_off = OFF_PLUS;  end
            default: begin off.row_off = OFF_ZERO; off.col_off = OFF_ZERO; end
        endcase
        return off;
    endfunction

endpackage

FILE: rtl/mlag_cell_ram.sv
// ----------------------------------------------------------------------------
// mlag_cell_ram
// Single-write, single-read cell memory with registered read data.
// ----------------------------------------------------------------------------
module mlag_cell_ram #(
    parameter int unsigned ADDR_W = 12,
    parameter int unsigned DATA_W = 8
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/mlag_rule_unit.sv
// ----------------------------------------------------------------------------
// mlag_rule_unit
// Shared neighbor counter and rule evaluator, fed one cell code per cycle.
// ----------------------------------------------------------------------------
module mlag_rule_unit
    import mlag_pkg::*;
(
    input  logic              aclk,
    input  cfg_t              cfg,
    input  step_ctl_t         ctl,
    input  logic [CODE_W-1:0] rd_data,
    output logic [CODE_W-1:0] wr_data
);

    logic [CODE_W-1:0]  center_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               live_hit;
    logic [COUNT_W-1:0] total;

    assign live_hit = (rd_data == cfg.live_code);
    assign total    = count_reg + COUNT_W'(live_hit);

    always_ff @(posedge aclk) begin
        if (ctl.load_center) begin
            center_reg <= rd_data;
            count_reg  <= '0;
        end else if (ctl.add_live) begin
            count_reg  <= total;
        end
    end

    // total already includes the last neighbor, which arrives in the write cycle
    always_comb begin
        wr_data = center_reg;
        if (ctl.copy) begin
            wr_data = rd_data;
        end else if (center_reg != cfg.frozen_code) begin
            case (cfg.rule_mode)
                RULE_LIFE: begin
                    if (center_reg == cfg.live_code) begin
                        if (total < SURVIVE_MIN || total > SURVIVE_MAX) begin
                            wr_data = cfg.empty_code;
                        end
                    end else if (total == BIRTH_COUNT) begin
                        wr_data = cfg.live_code;
                    end
                end
                RULE_CLEAN: begin
                    if (total < SURVIVE_MIN) begin
                        wr_data = cfg.empty_code;
                    end
                end
                RULE_FILL: begin
                    if (total > SURVIVE_MAX) begin
                        wr_data = cfg.live_code;
                    end
                end
                default: wr_data = center_reg;
            endcase
        end
    end

endmodule

FILE: rtl/mlag_sweep_ctrl.sv
// ----------------------------------------------------------------------------
// mlag_sweep_ctrl
// Sequencer that walks the grid cell by cell for every generation of a run.
// ----------------------------------------------------------------------------
module mlag_sweep_ctrl
    import mlag_pkg::*;
#(
    parameter int unsigned GRID_ROWS    = 64,
    parameter int unsigned GRID_COLUMNS = 64,
    localparam int unsigned ROW_W       = $clog2(GRID_ROWS),
    localparam int unsigned COL_W       = $clog2(GRID_COLUMNS)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [PASS_W-1:0]      pass_count,
    output logic                   busy,
    output logic                   done,
    output logic                   cur_bank,
    output logic                   rd_en,
    output logic [ROW_W+COL_W-1:0] rd_addr,
    output logic                   wr_en,
    output logic [ROW_W+COL_W-1:0] wr_addr,
    output step_ctl_t              ctl
);

    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GRID_ROWS - 1);
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(GRID_COLUMNS - 1);

    seq_state_t          state_reg, state_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [PASS_W-1:0]   gen_reg, gen_next;
    logic                bank_reg, bank_next;

    logic                sweeping;
    logic                border;
    logic [STEP_W-1:0]   last_step;
    nb_off_t             off;
    logic [ROW_W-1:0]    rd_row;
    logic [COL_W-1:0]    rd_col;
    logic                gen_end;
    logic                last_gen;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SEQ_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
            step_reg  <= STEP_CENTER;
            gen_reg   <= '0;
            bank_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            step_reg  <= step_next;
            gen_reg   <= gen_next;
            bank_reg  <= bank_next;
        end
    end

    always_comb begin
        sweeping  = (state_reg == SEQ_SWEEP);
        border    = (row_reg == '0) || (row_reg == LAST_ROW) ||
                    (col_reg == '0) || (col_reg == LAST_COL);
        // border cells are copied unchanged: read the center only
        last_step = border ? STEP_CENTER_DATA : STEP_FINAL;
        off       = nb_offset(step_reg);

        case (off.row_off)
            OFF_MINUS: rd_row = row_reg - ROW_W'(1);
            OFF_PLUS:  rd_row = row_reg + ROW_W'(1);
            default:   rd_row = row_reg;
        endcase
        case (off.col_off)
            OFF_MINUS: rd_col = col_reg - COL_W'(1);
            OFF_PLUS:  rd_col = col_reg + COL_W'(1);
            default:   rd_col = col_reg;
        endcase

        rd_addr = {rd_row, rd_col};
        wr_addr = {row_reg, col_reg};
        rd_en   = sweeping && (step_reg < last_step);
        wr_en   = sweeping && (step_reg == last_step);

        ctl.copy        = border;
        ctl.load_center = sweeping && !border && (step_reg == STEP_CENTER_DATA);
        ctl.add_live    = sweeping && (step_reg >= STEP_FIRST_NB) &&
                          (step_reg <= STEP_LAST_NB);

        gen_end  = wr_en && (row_reg == LAST_ROW) && (col_reg == LAST_COL);
        last_gen = (PASS_W'(gen_reg + PASS_W'(1)) == pass_count);
        done     = gen_end && last_gen;
        busy     = sweeping;
        cur_bank = bank_reg;

        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        step_next  = step_reg;
        gen_next   = gen_reg;
        bank_next  = bank_reg;

        case (state_reg)
            SEQ_IDLE: begin
                if (start) begin
                    state_next = SEQ_SWEEP;
                    row_next   = '0;
                    col_next   = '0;
                    step_next  = STEP_CENTER;
                    gen_next   = '0;
                end
            end
            SEQ_SWEEP: begin
                if (wr_en) begin
                    step_next = STEP_CENTER;
                    if (col_reg == LAST_COL) begin
                        col_next = '0;
                        if (row_reg == LAST_ROW) begin
                            // generation complete: swap buffers
                            row_next  = '0;
                            bank_next = !bank_reg;
                            gen_next  = PASS_W'(gen_reg + PASS_W'(1));
                            if (last_gen) begin
                                state_next = SEQ_IDLE;
                            end
                        end else begin
                            row_next = row_reg + ROW_W'(1);
                        end
                    end else begin
                        col_next = col_reg + COL_W'(1);
                    end
                end else begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            default: state_next = SEQ_IDLE;
        endcase
    end

    a_step_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        sweeping |-> (step_reg <= last_step))
        else $error("sweep step ran past the cell's last step");

    a_bank_swap_at_gen_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (bank_reg != $past(bank_reg)) |-> $past(gen_end))
        else $error("buffer swap outside a generation end");

    a_done_ends_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        done |=> (state_reg == SEQ_IDLE) && (gen_reg == pass_count))
        else $error("run finished with wrong generation count");

endmodule

FILE: rtl/masked_life_automaton_grid.sv
// ----------------------------------------------------------------------------
// masked_life_automaton_grid
// Double-buffered cell grid with host cell access and masked life generations.
// ----------------------------------------------------------------------------
// Cell writes and reads may follow back to back while their results are
// accepted; a read's value appears on the result channel the cycle after it
// is taken. A run holds s_tready low while it sweeps the grid pass_count
// times. Each generation reads the center and eight neighbors of every
// interior cell and only the center of every border cell, through the single
// read port of the cell memory that feeds the shared neighbor counter one
// code per cycle. A run with pass_count 0 answers at once.
// Cells must be written before they are read, directly or by a run.
module masked_life_automaton_grid
    import mlag_pkg::*;
#(
    parameter int unsigned GRID_ROWS    = 64,
    parameter int unsigned GRID_COLUMNS = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // s_tdata: operation[1:0], row[7:2], column[13:8], cell_value[21:14]
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // m_tdata: read_value[7:0], run_done[8]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int unsigned ROW_W     = $clog2(GRID_ROWS);
    localparam int unsigned COL_W     = $clog2(GRID_COLUMNS);
    localparam int unsigned ADDR_W    = ROW_W + COL_W;
    localparam int unsigned ROW_EXT_W = ((ROW_W > ROW_FIELD_W) ? ROW_W : ROW_FIELD_W) + 1;
    localparam int unsigned COL_EXT_W = ((COL_W > COL_FIELD_W) ? COL_W : COL_FIELD_W) + 1;

    // configuration
    logic [RULE_W-1:0] rule_mode_reg;
    logic [PASS_W-1:0] pass_count_reg;
    logic [CODE_W-1:0] empty_code_reg;
    logic [CODE_W-1:0] live_code_reg;
    logic [CODE_W-1:0] frozen_code_reg;
    logic              cfg_write;
    reg_idx_t          cfg_idx;
    cfg_t              cfg;

    // input fields
    logic [OP_W-1:0]        s_operation;
    logic [ROW_FIELD_W-1:0] s_row;
    logic [COL_FIELD_W-1:0] s_column;
    logic [CODE_W-1:0]      s_cell_value;
    logic [ROW_EXT_W-1:0]   row_ext;
    logic [COL_EXT_W-1:0]   col_ext;
    logic                   in_grid;
    logic [ADDR_W-1:0]      host_addr;
    logic                   accept;
    logic                   is_write;
    logic                   is_read;
    logic                   is_run;
    logic                   host_we;
    logic                   host_re;
    logic                   run_start;

    // result register
    logic out_valid_reg, out_valid_next;
    logic out_from_ram_reg, out_from_ram_next;
    logic out_done_reg, out_done_next;
    logic [CODE_W-1:0] read_value;

    // sweep
    logic              seq_busy;
    logic              seq_done;
    logic              cur_bank;
    logic              seq_rd_en;
    logic [ADDR_W-1:0] seq_rd_addr;
    logic              seq_wr_en;
    logic [ADDR_W-1:0] seq_wr_addr;
    step_ctl_t         seq_ctl;
    logic [CODE_W-1:0] seq_wr_data;
    logic [CODE_W-1:0] bank_q [2];
    logic [CODE_W-1:0] rd_q;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = reg_idx_t'(paddr[APB_ADDR_W-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rule_mode_reg   <= RULE_LIFE;
            pass_count_reg  <= PASS_W'(1);
            empty_code_reg  <= CODE_W'(0);
            live_code_reg   <= CODE_W'(1);
            frozen_code_reg <= CODE_W'(2);
        end else if (cfg_write) begin
            case (cfg_idx)
                REG_RULE_MODE:   rule_mode_reg   <= pwdata[RULE_W-1:0];
                REG_PASS_COUNT:  pass_count_reg  <= pwdata[PASS_W-1:0];
                REG_EMPTY_CODE:  empty_code_reg  <= pwdata[CODE_W-1:0];
                REG_LIVE_CODE:   live_code_reg   <= pwdata[CODE_W-1:0];
                REG_FROZEN_CODE: frozen_code_reg <= pwdata[CODE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_RULE_MODE:   prdata = APB_DATA_W'(rule_mode_reg);
            REG_PASS_COUNT:  prdata = APB_DATA_W'(pass_count_reg);
            REG_EMPTY_CODE:  prdata = APB_DATA_W'(empty_code_reg);
            REG_LIVE_CODE:   prdata = APB_DATA_W'(live_code_reg);
            REG_FROZEN_CODE: prdata = APB_DATA_W'(frozen_code_reg);
            default:         prdata = '0;
        endcase
    end

    assign cfg.rule_mode   = rule_mode_reg;
    assign cfg.empty_code  = empty_code_reg;
    assign cfg.live_code   = live_code_reg;
    assign cfg.frozen_code = frozen_code_reg;

    // ---------------- input decode ----------------
    assign s_operation  = s_tdata[1:0];
    assign s_row        = s_tdata[7:2];
    assign s_column     = s_tdata[13:8];
    assign s_cell_value = s_tdata[21:14];

    assign row_ext   = ROW_EXT_W'(s_row);
    assign col_ext   = COL_EXT_W'(s_column);
    assign in_grid   = (row_ext < ROW_EXT_W'(GRID_ROWS)) &&
                       (col_ext < COL_EXT_W'(GRID_COLUMNS));
    assign host_addr = {row_ext[ROW_W-1:0], col_ext[COL_W-1:0]};

    // take a new transaction whenever no run is busy and the result slot is free or being emptied
    assign s_tready  = !seq_busy && (!out_valid_reg || m_tready);
    assign accept    = s_tvalid && s_tready;
    assign is_write  = (s_operation == OP_WRITE);
    assign is_read   = (s_operation == OP_READ);
    assign is_run    = (s_operation == OP_RUN);
    assign host_we   = accept && is_write && in_grid;
    assign host_re   = accept && is_read && in_grid;
    assign run_start = accept && is_run && (pass_count_reg != '0);

    // ---------------- result register ----------------
    always_comb begin
        out_valid_next    = out_valid_reg;
        out_from_ram_next = out_from_ram_reg;
        out_done_next     = out_done_reg;
        if (accept) begin
            out_valid_next    = !run_start;
            out_from_ram_next = is_read && in_grid;
            out_done_next     = is_run;
        end else if (seq_done) begin
            out_valid_next    = 1'b1;
            out_from_ram_next = 1'b0;
            out_done_next     = 1'b1;
        end else if (m_tready) begin
            out_valid_next    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg    <= 1'b0;
            out_from_ram_reg <= 1'b0;
            out_done_reg     <= 1'b0;
        end else begin
            out_valid_reg    <= out_valid_next;
            out_from_ram_reg <= out_from_ram_next;
            out_done_reg     <= out_done_next;
        end
    end

    // read data holds in the memory output register until the result is taken
    assign rd_q       = bank_q[cur_bank];
    assign read_value = out_from_ram_reg ? rd_q : CODE_W'(0);
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {7'd0, out_done_reg, read_value};

    // ---------------- sweep engine ----------------
    mlag_sweep_ctrl #(
        .GRID_ROWS    (GRID_ROWS),
        .GRID_COLUMNS (GRID_COLUMNS)
    ) u_sweep (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (run_start),
        .pass_count (pass_count_reg),
        .busy       (seq_busy),
        .done       (seq_done),
        .cur_bank   (cur_bank),
        .rd_en      (seq_rd_en),
        .rd_addr    (seq_rd_addr),
        .wr_en      (seq_wr_en),
        .wr_addr    (seq_wr_addr),
        .ctl        (seq_ctl)
    );

    mlag_rule_unit u_rule (
        .aclk    (aclk),
        .cfg     (cfg),
        .ctl     (seq_ctl),
        .rd_data (rd_q),
        .wr_data (seq_wr_data)
    );

    // current bank serves the host and the sweep reads; the other takes the
    // next generation
    for (genvar b = 0; b < 2; b++) begin : g_bank
        logic sel;
        assign sel = (cur_bank == 1'(b));

        mlag_cell_ram #(
            .ADDR_W (ADDR_W),
            .DATA_W (CODE_W)
        ) u_ram (
            .aclk  (aclk),
            .we    (sel ? host_we : seq_wr_en),
            .waddr (sel ? host_addr : seq_wr_addr),
            .wdata (sel ? s_cell_value : seq_wr_data),
            .re    (sel && (host_re || seq_rd_en)),
            .raddr (seq_busy ? seq_rd_addr : host_addr),
            .rdata (bank_q[b])
        );
    end

    a_no_result_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        !(out_valid_reg && seq_busy))
        else $error("result pending during a run");

    a_done_has_no_read: assert property (@(posedge aclk) disable iff (!aresetn)
        out_done_reg |-> !out_from_ram_reg)
        else $error("run result carries read data");

    a_run_goes_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        run_start |=> (seq_busy && !m_tvalid))
        else $error("run did not start the sweep");

endmodule
